FILE: src/mbet_pkg.sv
// Package for the escape-time unit: fixed-point widths, register indexes,
// word types for the command, result, configuration and multiplier buses.
// No dependencies.
package mbet_pkg;

    localparam int FRAC_BITS  = 28;
    localparam int COORD_W    = 32;
    localparam int IDX_W      = 12;
    localparam int CNT_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int Z_W        = COORD_W + 1;
    localparam int OP_W       = Z_W;
    localparam int PROD_W     = 2 * OP_W;

    localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_STEP      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_STEP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT  = 3'd4;

    localparam logic [CNT_W-1:0] LIMIT_RESET = 10'd1023;

    typedef struct packed {
        logic [IDX_W-1:0] column;
        logic [IDX_W-1:0] row;
    } item_t;

    typedef struct packed {
        logic [CNT_W-1:0] escape_count;
        logic             shortcut_hit;
    } result_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_origin;
        logic signed [COORD_W-1:0] x_step;
        logic signed [COORD_W-1:0] y_origin;
        logic signed [COORD_W-1:0] y_step;
        logic [CNT_W-1:0]          iteration_limit;
    } cfg_t;

    typedef struct packed {
        logic signed [OP_W-1:0] a0;
        logic signed [OP_W-1:0] b0;
        logic signed [OP_W-1:0] a1;
        logic signed [OP_W-1:0] b1;
        logic signed [OP_W-1:0] a2;
        logic signed [OP_W-1:0] b2;
    } mul_req_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] p0;
        logic signed [PROD_W-1:0] p1;
        logic signed [PROD_W-1:0] p2;
    } mul_rsp_t;

endpackage

FILE: src/mbet_cfg_regs.sv
// Configuration register file of the escape-time unit.
// Depends on mbet_pkg.
module mbet_cfg_regs
    import mbet_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_X_ORIGIN:   cfg_next.x_origin = signed'(cfg_wdata[COORD_W-1:0]);
                REG_X_STEP:     cfg_next.x_step = signed'(cfg_wdata[COORD_W-1:0]);
                REG_Y_ORIGIN:   cfg_next.y_origin = signed'(cfg_wdata[COORD_W-1:0]);
                REG_Y_STEP:     cfg_next.y_step = signed'(cfg_wdata[COORD_W-1:0]);
                REG_ITER_LIMIT: cfg_next.iteration_limit = cfg_wdata[CNT_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_origin        <= '0;
            cfg_reg.x_step          <= '0;
            cfg_reg.y_origin        <= '0;
            cfg_reg.y_step          <= '0;
            cfg_reg.iteration_limit <= LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: src/mbet_mul3.sv
// Shared multiplier bank: three signed products, used by every step.
// Depends on mbet_pkg.
module mbet_mul3
    import mbet_pkg::*;
(
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    always_comb
    begin
        rsp.p0 = req.a0 * req.b0;
        rsp.p1 = req.a1 * req.b1;
        rsp.p2 = req.a2 * req.b2;
    end

endmodule

FILE: src/mbet_core.sv
// Sequencer and datapath registers: coordinate, shortcut test, iteration.
// Depends on mbet_pkg; drives the shared multiplier bank.
module mbet_core
    import mbet_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  item_t    item,
    input  cfg_t     cfg,
    output logic     busy,
    output logic     done,
    output result_t  result,
    output mul_req_t mul_req,
    input  mul_rsp_t mul_rsp
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_COORD = 3'd1;
    localparam logic [2:0] ST_SC1   = 3'd2;
    localparam logic [2:0] ST_SC2   = 3'd3;
    localparam logic [2:0] ST_ITER  = 3'd4;

    localparam int SUM_W = COORD_W + IDX_W + 2;
    localparam int SQ_W  = 2 * FRAC_BITS + 4;
    localparam int SCS_W = 2 * FRAC_BITS + 6;
    localparam int Q_W   = COORD_W;
    localparam int RHS_W = SQ_W - 2;

    localparam logic signed [COORD_W-1:0] TWO_C   = COORD_W'(64'd1 << (FRAC_BITS + 1));
    localparam logic signed [Z_W-1:0]     TWO_Z   = Z_W'(64'd1 << (FRAC_BITS + 1));
    localparam logic signed [Z_W-1:0]     QUART_Z = Z_W'(64'd1 << (FRAC_BITS - 2));
    localparam logic signed [Z_W-1:0]     ONE_Z   = Z_W'(64'd1 << FRAC_BITS);
    localparam logic [SQ_W-1:0]  FOUR_SQ  = SQ_W'(64'd1 << (2 * FRAC_BITS + 2));
    localparam logic [SCS_W-1:0] BULB_LIM = SCS_W'(64'd1 << (2 * FRAC_BITS - 4));

    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-COORD_W:0] top;
        begin
            top = s[SUM_W-1:COORD_W-1];
            if (s[SUM_W-1] && !(&top))
                sat_coord = {1'b1, {(COORD_W-1){1'b0}}};
            else if (!s[SUM_W-1] && (|top))
                sat_coord = {1'b0, {(COORD_W-1){1'b1}}};
            else
                sat_coord = s[COORD_W-1:0];
        end
    endfunction

    logic [2:0]                state_reg, state_next;
    logic [IDX_W-1:0]          col_reg, col_next;
    logic [IDX_W-1:0]          row_reg, row_next;
    logic signed [COORD_W-1:0] cr_reg, cr_next;
    logic signed [COORD_W-1:0] ci_reg, ci_next;
    logic                      inrange_reg, inrange_next;
    logic [Q_W-1:0]            q_reg, q_next;
    logic signed [Z_W-1:0]     qa_reg, qa_next;
    logic [RHS_W-1:0]          rhs_reg, rhs_next;
    logic                      bulb_reg, bulb_next;
    logic signed [Z_W-1:0]     x_reg, x_next;
    logic signed [Z_W-1:0]     y_reg, y_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      done_reg, done_next;
    result_t                   result_reg, result_next;

    logic signed [Z_W-1:0]     cr_ext, ci_ext, a_val, b_val;
    logic signed [SUM_W-1:0]   cx_sum, cy_sum;
    logic [SCS_W-1:0]          sc_sum, bulb_sum;
    logic signed [PROD_W-1:0]  rhs_ext;
    logic                      hit;
    logic                      esc_range, esc_mag;
    logic [SQ_W-1:0]           sq_sum;
    logic signed [SQ_W-1:0]    diff, diff_sh, xy, xy_sh;

    assign cr_ext = {cr_reg[COORD_W-1], cr_reg};
    assign ci_ext = {ci_reg[COORD_W-1], ci_reg};
    assign a_val  = cr_ext - QUART_Z;
    assign b_val  = cr_ext + ONE_Z;

    // operand steering for the shared multipliers
    always_comb
    begin
        mul_req = '0;
        case (state_reg)
            ST_COORD:
            begin
                mul_req.a0 = signed'({{(OP_W-IDX_W){1'b0}}, col_reg});
                mul_req.b0 = {cfg.x_step[COORD_W-1], cfg.x_step};
                mul_req.a1 = signed'({{(OP_W-IDX_W){1'b0}}, row_reg});
                mul_req.b1 = {cfg.y_step[COORD_W-1], cfg.y_step};
            end
            ST_SC1:
            begin
                mul_req.a0 = a_val;
                mul_req.b0 = a_val;
                mul_req.a1 = ci_ext;
                mul_req.b1 = ci_ext;
                mul_req.a2 = b_val;
                mul_req.b2 = b_val;
            end
            ST_SC2:
            begin
                mul_req.a0 = signed'({1'b0, q_reg});
                mul_req.b0 = qa_reg;
            end
            ST_ITER:
            begin
                mul_req.a0 = x_reg;
                mul_req.b0 = x_reg;
                mul_req.a1 = y_reg;
                mul_req.b1 = y_reg;
                mul_req.a2 = x_reg;
                mul_req.b2 = y_reg;
            end
            default:
            begin
                mul_req = '0;
            end
        endcase
    end

    // c = origin + index * step, saturated
    assign cx_sum = SUM_W'(cfg.x_origin) + mul_rsp.p0[SUM_W-1:0];
    assign cy_sum = SUM_W'(cfg.y_origin) + mul_rsp.p1[SUM_W-1:0];

    // shortcut terms; squares are small whenever c is in range
    assign sc_sum   = {1'b0, mul_rsp.p0[SCS_W-2:0]} + {1'b0, mul_rsp.p1[SCS_W-2:0]};
    assign bulb_sum = {1'b0, mul_rsp.p2[SCS_W-2:0]} + {1'b0, mul_rsp.p1[SCS_W-2:0]};
    assign rhs_ext  = signed'({{(PROD_W-RHS_W){1'b0}}, rhs_reg});
    assign hit      = inrange_reg && ((mul_rsp.p0 < rhs_ext) || bulb_reg);

    // iteration terms
    assign esc_range = (x_reg >= TWO_Z) || (x_reg <= -TWO_Z) ||
                       (y_reg >= TWO_Z) || (y_reg <= -TWO_Z);
    assign sq_sum    = mul_rsp.p0[SQ_W-1:0] + mul_rsp.p1[SQ_W-1:0];
    assign esc_mag   = sq_sum >= FOUR_SQ;
    assign diff      = signed'(mul_rsp.p0[SQ_W-1:0]) - signed'(mul_rsp.p1[SQ_W-1:0]);
    assign diff_sh   = diff >>> FRAC_BITS;
    assign xy        = signed'(mul_rsp.p2[SQ_W-1:0]);
    assign xy_sh     = xy >>> (FRAC_BITS - 1);

    always_comb
    begin
        state_next   = state_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        cr_next      = cr_reg;
        ci_next      = ci_reg;
        inrange_next = inrange_reg;
        q_next       = q_reg;
        qa_next      = qa_reg;
        rhs_next     = rhs_reg;
        bulb_next    = bulb_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        count_next   = count_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    col_next   = item.column;
                    row_next   = item.row;
                    state_next = ST_COORD;
                end
            end
            ST_COORD:
            begin
                cr_next    = sat_coord(cx_sum);
                ci_next    = sat_coord(cy_sum);
                state_next = ST_SC1;
            end
            ST_SC1:
            begin
                inrange_next = (cr_reg < TWO_C) && (cr_reg > -TWO_C) &&
                               (ci_reg < TWO_C) && (ci_reg > -TWO_C);
                q_next       = sc_sum[FRAC_BITS+Q_W-1:FRAC_BITS];
                qa_next      = signed'({1'b0, q_next}) + a_val;
                rhs_next     = mul_rsp.p1[SQ_W-1:2];
                bulb_next    = bulb_sum < BULB_LIM;
                state_next   = ST_SC2;
            end
            ST_SC2:
            begin
                x_next     = '0;
                y_next     = '0;
                count_next = '0;
                if (hit)
                begin
                    result_next.escape_count = cfg.iteration_limit;
                    result_next.shortcut_hit = 1'b1;
                    done_next                = 1'b1;
                    state_next               = ST_IDLE;
                end
                else
                begin
                    state_next = ST_ITER;
                end
            end
            ST_ITER:
            begin
                if ((count_reg == cfg.iteration_limit) || esc_range || esc_mag)
                begin
                    result_next.escape_count = count_reg;
                    result_next.shortcut_hit = 1'b0;
                    done_next                = 1'b1;
                    state_next               = ST_IDLE;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    x_next     = diff_sh[Z_W-1:0] + cr_ext;
                    y_next     = xy_sh[Z_W-1:0] + ci_ext;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg     <= col_next;
        row_reg     <= row_next;
        cr_reg      <= cr_next;
        ci_reg      <= ci_next;
        inrange_reg <= inrange_next;
        q_reg       <= q_next;
        qa_reg      <= qa_next;
        rhs_reg     <= rhs_next;
        bulb_reg    <= bulb_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        count_reg   <= count_next;
        result_reg  <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: src/mandelbrot_escape_time.sv
// Escape-time unit: once start is taken it runs the coordinate step, two shortcut
// steps and n iterations (n <= iteration_limit), then strobes done; a cardioid/bulb
// hit skips the iterations. One z = z*z + c iteration per cycle on one shared
// multiplier bank sets the rate; a new start is taken in the cycle done is high.
// Results cannot be stalled. rst_n async, active low: idle, no strobe, config
// registers back to reset values. Depends on mbet_pkg, mbet_cfg_regs, mbet_mul3, mbet_core.
module mandelbrot_escape_time
    import mbet_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // command side
    input  logic                  start,
    input  item_t                 item,
    output logic                  busy,
    // result side
    output logic                  done,
    output result_t               result,
    // configuration writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t     cfg;
    mul_req_t mul_req;
    mul_rsp_t mul_rsp;

    // origin/step/limit registers; the user writes them only while idle, the block does not enforce it
    mbet_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // three signed 33x33 products; the sequencer picks the operands
    // per step: coordinate, shortcut squares, shortcut product, iteration
    mbet_mul3 u_mul3 (
        .req (mul_req),
        .rsp (mul_rsp)
    );

    // step sequence: coord -> cardioid/bulb terms -> cardioid product
    // -> iterate until escape or count reaches the limit
    mbet_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .item    (item),
        .cfg     (cfg),
        .busy    (busy),
        .done    (done),
        .result  (result),
        .mul_req (mul_req),
        .mul_rsp (mul_rsp)
    );

    // the unit only goes idle by delivering a word
    a_idle_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result word");

    // a count never exceeds the limit it ran against
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.escape_count <= cfg.iteration_limit))
        else $error("escape count above iteration limit");

    // shortcut word carries the full limit
    a_shortcut_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.shortcut_hit) |-> (result.escape_count == cfg.iteration_limit))
        else $error("shortcut word without limit count");

    // an accepted word starts work right away
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted start did not raise busy");

endmodule

FILE: tb/mandelbrot_escape_time_tb.sv
// Self-checking testbench for the escape-time unit: directed pixels, then randomly
// zoomed views with random idle gaps, checked word by word against a predictor.
// Depends on mbet_pkg and mandelbrot_escape_time.
module mandelbrot_escape_time_tb;
    import mbet_pkg::*;

    // ------------------------------------------------------------------
    // Predictor and scoreboard
    // ------------------------------------------------------------------
    // Keeps its own copy of the view registers, works out each pixel's
    // expected word when the unit takes it, and checks results in order.
    typedef struct {
        item_t   pixel;
        result_t word;
    } awaited_t;

    class escape_count_board;
        logic signed [COORD_W-1:0] x_origin;
        logic signed [COORD_W-1:0] x_step;
        logic signed [COORD_W-1:0] y_origin;
        logic signed [COORD_W-1:0] y_step;
        logic [CNT_W-1:0]          iter_limit;
        awaited_t                  awaited[$];
        int unsigned               mismatches;

        function new();
            x_origin   = '0;
            x_step     = '0;
            y_origin   = '0;
            y_step     = '0;
            iter_limit = LIMIT_RESET;
            mismatches = 0;
        endfunction

        // Indexes past the last register are dropped by the unit.
        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_X_ORIGIN:   x_origin = data;
                REG_X_STEP:     x_step = data;
                REG_Y_ORIGIN:   y_origin = data;
                REG_Y_STEP:     y_step = data;
                REG_ITER_LIMIT: iter_limit = data[CNT_W-1:0];
                default:        ;
            endcase
        endfunction

        // origin + index * step, saturated to 32-bit signed
        function longint coord_of(longint origin, longint index, longint step);
            longint v;
            v = origin + index * step;
            if (v > longint'(32'sh7FFF_FFFF))
                v = longint'(32'sh7FFF_FFFF);
            if (v < longint'(32'sh8000_0000))
                v = longint'(32'sh8000_0000);
            return v;
        endfunction

        function result_t escape_of(item_t w);
            longint  cr, ci, a, q, b, x, y, xx, yy, xy, two, four;
            int      n;
            result_t r;
            two  = longint'(2) <<< FRAC_BITS;
            four = longint'(4) <<< (2 * FRAC_BITS);
            cr = coord_of(longint'(x_origin), longint'(w.column), longint'(x_step));
            ci = coord_of(longint'(y_origin), longint'(w.row), longint'(y_step));
            r.shortcut_hit = 1'b0;
            r.escape_count = '0;
            // cardioid / period-2 bulb, only meaningful inside |c| < 2 box
            if (cr < two && cr > -two && ci < two && ci > -two) begin
                a = cr - (longint'(1) <<< (FRAC_BITS - 2));
                q = (a * a + ci * ci) >>> FRAC_BITS;
                b = cr + (longint'(1) <<< FRAC_BITS);
                if (q * (q + a) < ((ci * ci) >>> 2)
                        || b * b + ci * ci < (longint'(1) <<< (2 * FRAC_BITS - 4)))
                    r.shortcut_hit = 1'b1;
            end
            if (r.shortcut_hit) begin
                r.escape_count = iter_limit;
                return r;
            end
            x = 0;
            y = 0;
            n = 0;
            while (n < int'(iter_limit)) begin
                if (x >= two || x <= -two || y >= two || y <= -two)
                    break;
                xx = x * x;
                yy = y * y;
                if (xx + yy >= four)
                    break;
                n++;
                xy = x * y;
                x = ((xx - yy) >>> FRAC_BITS) + cr;
                y = ((2 * xy) >>> FRAC_BITS) + ci;
            end
            r.escape_count = n[CNT_W-1:0];
            return r;
        endfunction

        function void note_pixel(item_t w);
            awaited_t e;
            e.pixel = w;
            e.word  = escape_of(w);
            awaited.push_back(e);
        endfunction

        function void check_word(result_t got);
            awaited_t e;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: count %0d hit %0b",
                             got.escape_count, got.shortcut_hit);
                return;
            end
            e = awaited.pop_front();
            if (got.escape_count !== e.word.escape_count
                    || got.shortcut_hit !== e.word.shortcut_hit) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch col %0d row %0d: expected %0d/%0b, got %0d/%0b",
                             e.pixel.column, e.pixel.row, e.word.escape_count,
                             e.word.shortcut_hit, got.escape_count, got.shortcut_hit);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT and clock
    // ------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  start;
    item_t                 item;
    logic                  busy;
    logic                  done;
    result_t               result;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    escape_count_board board;

    mandelbrot_escape_time dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Result side: the unit strobes done for one cycle and cannot be held
    // off, so every strobe seen at an edge is a word to check.
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_word(result);
    end

    // ------------------------------------------------------------------
    // Drivers. All run on posedge-aligned steps and drive with NBAs.
    // ------------------------------------------------------------------

    // Present one pixel and hold it until the unit takes it (start && !busy).
    // start is left high so back-to-back words see no gap; the caller lowers
    // it through hold_off or drain_pixels.
    task automatic issue_pixel(input item_t w);
        start <= 1'b1;
        item  <= w;
        do @(posedge clk); while (busy !== 1'b0);
        board.note_pixel(w);
    endtask

    // Sender idle: start low with junk on the item bus.
    task automatic hold_off(input int cycles);
        start <= 1'b0;
        item  <= {IDX_W'($urandom), IDX_W'($urandom)};
        repeat (cycles) @(posedge clk);
    endtask

    // Stop sending and wait until every pixel in flight has reported.
    // Always waits on the clock first, so start never toggles in one step.
    task automatic drain_pixels();
        start <= 1'b0;
        do @(posedge clk); while (board.awaited.size() != 0);
    endtask

    // Write all five view registers (unit idle). The limit write carries
    // junk above bit 9, and now and then a write to an unused index follows.
    task automatic load_view(input int xo, input int xs, input int yo, input int ys,
                             input logic [CNT_W-1:0] lim);
        logic [CFG_IDX_W-1:0]  idx [6];
        logic [CFG_DATA_W-1:0] data [6];
        int                    n;
        idx[0]  = REG_X_ORIGIN;
        data[0] = xo;
        idx[1]  = REG_X_STEP;
        data[1] = xs;
        idx[2]  = REG_Y_ORIGIN;
        data[2] = yo;
        idx[3]  = REG_Y_STEP;
        data[3] = ys;
        idx[4]  = REG_ITER_LIMIT;
        data[4] = {(CFG_DATA_W - CNT_W)'($urandom), lim};
        n = 5;
        if ($urandom_range(0, 2) == 0) begin
            idx[5]  = REG_ITER_LIMIT + CFG_IDX_W'($urandom_range(1, 3));
            data[5] = $urandom;
            n = 6;
        end
        cfg_wr_en <= 1'b1;
        for (int i = 0; i < n; i++) begin
            cfg_index <= idx[i];
            cfg_wdata <= data[i];
            @(posedge clk);
            board.set_register(idx[i], data[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // One random view: picks a limit and a window, then sends pixels with
    // random gaps (none when idle_ok is clear). Halfway through, if idle_ok is set, the
    // sender waits for the unit to empty out completely.
    task automatic random_view_phase(input int n_items, input bit idle_ok);
        int               xo, xs, yo, ys;
        logic [CNT_W-1:0] lim;
        item_t            w;
        case ($urandom_range(0, 5))
            0:       lim = LIMIT_RESET;
            1:       lim = CNT_W'($urandom_range(1, 8));
            2:       lim = CNT_W'($urandom_range(9, 127));
            5:       lim = '0;
            default: lim = CNT_W'($urandom_range(128, 1023));
        endcase
        case ($urandom_range(0, 9))
            // overview of the set, either scan direction
            0, 1, 2, 3, 4, 5: begin
                xs = int'($urandom_range(1 << 16, 1 << 18));
                xo = -(5 <<< 27) + int'($urandom_range(0, 1 << 27));
                ys = int'($urandom_range(1 << 15, 1 << 18));
                yo = -(3 <<< 27) + int'($urandom_range(0, 1 << 26));
                if ($urandom_range(0, 1)) begin
                    xo = (1 <<< 28) + int'($urandom_range(0, 1 << 26));
                    xs = -xs;
                end
                if ($urandom_range(0, 1)) begin
                    yo = -yo;
                    ys = -ys;
                end
            end
            // deep zoom around the cardioid/bulb neck, where counts run long
            6, 7: begin
                xs = int'($urandom_range(1, 1 << 12));
                ys = int'($urandom_range(1, 1 << 12));
                xo = -(3 <<< 26) - 2048 * xs + int'($urandom_range(0, 1 << 24));
                yo = (1 <<< 24) - 2048 * ys + int'($urandom_range(0, 1 << 24));
            end
            // raw register values: saturation and far-out points
            default: begin
                xo = $urandom;
                xs = $urandom;
                yo = $urandom;
                ys = $urandom;
            end
        endcase
        load_view(xo, xs, yo, ys, lim);
        for (int i = 0; i < n_items; i++) begin
            if (idle_ok && $urandom_range(0, 99) < 21)
                hold_off(($urandom_range(0, 9) == 0) ? $urandom_range(7, 60)
                                                      : $urandom_range(1, 6));
            if (idle_ok && i == n_items / 2)
                drain_pixels();
            w.column = IDX_W'($urandom_range(0, 4095));
            w.row    = IDX_W'($urandom_range(0, 4095));
            issue_pixel(w);
        end
        drain_pixels();
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        board     = new();
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_X_ORIGIN;
        cfg_wdata = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers at reset: every pixel maps to c = 0, a cardioid hit
        // reported with the full reset limit.
        issue_pixel('{12'd0, 12'd0});
        issue_pixel('{12'd4095, 12'd4095});
        issue_pixel('{12'd4095, 12'd0});
        drain_pixels();

        // -2-2i origin, 1/256 per pixel, limit at max
        load_view(-(1 <<< 29), 1 <<< 20, -(1 <<< 29), 1 <<< 20, LIMIT_RESET);
        issue_pixel('{12'd256, 12'd512});    // c = -1: bulb center
        issue_pixel('{12'd448, 12'd512});    // c = -0.25: inside cardioid
        issue_pixel('{12'd320, 12'd512});    // c = -0.75: cardioid/bulb join
        issue_pixel('{12'd576, 12'd512});    // c = 0.25: cusp, runs to limit
        issue_pixel('{12'd0, 12'd512});      // c = -2: on the escape edge
        issue_pixel('{12'd1024, 12'd512});   // past image width, c = 2
        issue_pixel('{12'd512, 12'd1024});   // c = 2i, shortcut box edge
        issue_pixel('{12'd640, 12'd512});    // c = 0.5: escapes in a few
        issue_pixel('{12'd576, 12'd768});    // c = 0.25+i
        issue_pixel('{12'd300, 12'd700});
        issue_pixel('{12'd4095, 12'd4095});  // both coordinates saturate high
        drain_pixels();

        // Most negative step and origin on x, most positive on y; limit 1
        load_view(int'(32'h8000_0000), int'(32'h8000_0000),
                  int'(32'h7FFF_FFFF), int'(32'h7FFF_FFFF), 10'd1);
        issue_pixel('{12'd0, 12'd0});
        issue_pixel('{12'd1, 12'd1});
        issue_pixel('{12'd2048, 12'd1});
        issue_pixel('{12'd4095, 12'd4095});
        drain_pixels();

        // Limit of zero: no iterations, count 0 even on a shortcut hit
        load_view(0, 1 <<< 22, 0, 1 <<< 22, '0);
        issue_pixel('{12'd0, 12'd0});
        issue_pixel('{12'd100, 12'd0});
        issue_pixel('{12'd4095, 12'd4095});
        drain_pixels();

        // Random views; phase 4 runs with the sender never idling
        for (int p = 0; p < 10; p++)
            random_view_phase(56, p != 4);

        // Stray strobes after the last word would show up here
        repeat (1030) @(posedge clk);
        if (board.mismatches == 0 && board.awaited.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog, several times the slowest legal run
    initial
    begin
        #40000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
